// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the cluster table engine. Clock and reset are
// taken from the enclosing module as clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared widths, operation codes and row control types of the FAT12 cluster
// table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fct_pkg;

   localparam int OP_W      = 3;
   localparam int CLUSTER_W = 12;
   localparam int ADDR_W    = 13;
   localparam int BYTE_W    = 8;
   localparam int LIMIT_W   = 13;
   localparam int ENTRY_W   = 12;
   localparam int ROW_DW    = 2 * ENTRY_W;   // one row = two packed entries = 3 bytes
   localparam int PROD_W    = 2 * ADDR_W;

   localparam int CLUSTERS_DEFAULT = 4096;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // byte_address / 3 as (addr * DIV3_MUL) >> DIV3_SHIFT, exact for 13-bit addresses
   localparam logic [ADDR_W-1:0] DIV3_MUL   = 13'd5462;
   localparam int                DIV3_SHIFT = 14;

   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 12'h000;
   localparam logic [ENTRY_W-1:0] ENTRY_FULL = 12'hFFF;

   localparam logic [OP_W-1:0] OP_READ = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE = 3'd1;
   localparam logic [OP_W-1:0] OP_FULL = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD = 3'd4;

   localparam logic [1:0] LANE_B0 = 2'd0;
   localparam logic [1:0] LANE_B1 = 2'd1;
   localparam logic [1:0] LANE_B2 = 2'd2;

   typedef struct packed {
      logic       odd;    // odd entry of the row
      logic       load;   // raw byte write instead of entry write
      logic [1:0] lane;   // byte lane for raw byte write
   } row_ctl_type;

   typedef struct packed {
      logic even_zero;
      logic odd_zero;
   } row_stat_type;

endpackage

// ===== rtl/fct_table_ram.sv =====
// ----------------------------------------------------------------------------
// fct_table_ram
// Table row store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_table_ram #(
   parameter int DEPTH  = fct_pkg::CLUSTERS_DEFAULT / 2,
   parameter int AW     = $clog2(DEPTH),
   parameter int DW     = fct_pkg::ROW_DW
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fct_row_unit.sv =====
// ----------------------------------------------------------------------------
// fct_row_unit
// Shared row unit: unpacks the two 12-bit entries of a row, merges a new
// entry or raw byte into it, and flags free entries for the search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_row_unit (
   input  logic [fct_pkg::ROW_DW-1:0]  row_data,
   input  fct_pkg::row_ctl_type        ctl,
   input  logic [fct_pkg::ENTRY_W-1:0] entry_new,
   input  logic [fct_pkg::BYTE_W-1:0]  byte_new,
   output logic [fct_pkg::ENTRY_W-1:0] entry_sel,
   output logic [fct_pkg::ROW_DW-1:0]  row_new,
   output fct_pkg::row_stat_type       stat
);

   logic [fct_pkg::ENTRY_W-1:0] even_entry;
   logic [fct_pkg::ENTRY_W-1:0] odd_entry;

   // byte 3k = row[7:0], 3k+1 = row[15:8], 3k+2 = row[23:16]
   assign even_entry = row_data[fct_pkg::ENTRY_W-1:0];
   assign odd_entry  = row_data[fct_pkg::ROW_DW-1:fct_pkg::ENTRY_W];

   assign entry_sel = ctl.odd ? odd_entry : even_entry;

   assign stat.even_zero = (even_entry == fct_pkg::ENTRY_FREE);
   assign stat.odd_zero  = (odd_entry == fct_pkg::ENTRY_FREE);

   always_comb begin
      if (ctl.load) begin
         case (ctl.lane)
            fct_pkg::LANE_B0: row_new = {row_data[23:8], byte_new};
            fct_pkg::LANE_B1: row_new = {row_data[23:16], byte_new, row_data[7:0]};
            fct_pkg::LANE_B2: row_new = {byte_new, row_data[15:0]};
            default:          row_new = row_data;
         endcase
      end else if (ctl.odd) begin
         row_new = {entry_new, even_entry};
      end else begin
         row_new = {odd_entry, entry_new};
      end
   end

endmodule

// ===== rtl/fat12_cluster_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_core
// FAT12 allocation table engine: raw byte load, entry read, free, mark full
// and lowest-free-entry search over a packed table store.
// ----------------------------------------------------------------------------
// After reset the block clears all (CLUSTERS+1)/2 table rows (2048 by
// default), one table row per cycle, and holds req_stall high meanwhile; csr
// writes are taken during the pass. The store is organized as rows of three
// bytes, two entries per row, behind a single-read-port RAM. Read, free, mark
// full, load byte and undefined operations pass through accept, row read and
// row update/result; the result step waits while the output register is held.
// A find visits the rows from cluster 2 up to the hit or to the search limit:
// each row costs one RAM read and one check of both entries, and a miss ends
// with a final limit check. One item is in flight at a time; a finished
// result waits in the output register while the next beat is accepted.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fat12_cluster_table_engine_core #(
   parameter int CLUSTERS = fct_pkg::CLUSTERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_wr_en,
   input  logic [fct_pkg::LIMIT_W-1:0]   csr_wr_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fct_pkg::OP_W-1:0]      req_operation,
   input  logic [fct_pkg::CLUSTER_W-1:0] req_cluster,
   input  logic [fct_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [fct_pkg::BYTE_W-1:0]    req_byte_value,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fct_pkg::ENTRY_W-1:0]   rsp_entry_value,
   output logic                          rsp_found,
   output logic [fct_pkg::CLUSTER_W-1:0] rsp_free_cluster
);

   localparam int ROWS       = (CLUSTERS + 1) / 2;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int TABLE_SIZE = ROWS * 3;
   localparam int LW         = fct_pkg::LIMIT_W;
   localparam int CW         = fct_pkg::CLUSTER_W;
   localparam int EW         = fct_pkg::ENTRY_W;
   localparam int AW         = fct_pkg::ADDR_W;

   localparam logic [LW-1:0]    CLUSTER_END = LW'(CLUSTERS);
   localparam logic [AW:0]      TABLE_END   = (AW + 1)'(TABLE_SIZE);
   localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [LW-1:0]    FIRST_FIND  = 13'd2;

   typedef enum logic [5:0] {
      S_CLEAR    = 6'b000001,
      S_IDLE     = 6'b000010,
      S_ISSUE    = 6'b000100,
      S_EXEC     = 6'b001000,
      S_FIND_RD  = 6'b010000,
      S_FIND_CHK = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [ROW_W-1:0]             clr_ff, clr_in;
   logic [LW-1:0]                limit_ff, limit_in;
   logic [LW-1:0]                scan_ff, scan_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [fct_pkg::OP_W-1:0]     op_ff;
   logic [CW-1:0]                cluster_ff;
   logic [AW-1:0]                addr_ff;
   logic [fct_pkg::BYTE_W-1:0]   value_ff;
   logic [fct_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [1:0]                   lane_ff;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [EW-1:0]                rsp_entry_ff, rsp_entry_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [CW-1:0]                rsp_free_ff, rsp_free_in;

   logic                         accept;
   logic                         out_free;
   logic                         push;
   logic [LW-1:0]                end_cl;
   logic                         cluster_ok;
   logic                         addr_ok;
   logic [CW-1:0]                div_row;
   logic [AW-1:0]                div_back;
   logic [AW-1:0]                lane_full;
   logic                         scan_done;
   logic [LW-1:0]                scan_odd;
   logic                         even_hit;
   logic                         odd_hit;

   logic                         ram_wr_en;
   logic [ROW_W-1:0]             ram_wr_addr;
   logic [fct_pkg::ROW_DW-1:0]   ram_wr_data;
   logic                         ram_rd_en;
   logic [ROW_W-1:0]             ram_rd_addr;
   logic [fct_pkg::ROW_DW-1:0]   ram_rd_data;

   fct_pkg::row_ctl_type         row_ctl;
   fct_pkg::row_stat_type        row_stat;
   logic [EW-1:0]                row_entry;
   logic [fct_pkg::ROW_DW-1:0]   row_merged;

   fct_table_ram #(
      .DEPTH (ROWS),
      .AW    (ROW_W),
      .DW    (fct_pkg::ROW_DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign row_ctl.odd  = cluster_ff[0];
   assign row_ctl.load = (op_ff == fct_pkg::OP_LOAD);
   assign row_ctl.lane = lane_ff;

   fct_row_unit u_row (
      .row_data  (ram_rd_data),
      .ctl       (row_ctl),
      .entry_new ((op_ff == fct_pkg::OP_FULL) ? fct_pkg::ENTRY_FULL : fct_pkg::ENTRY_FREE),
      .byte_new  (value_ff),
      .entry_sel (row_entry),
      .row_new   (row_merged),
      .stat      (row_stat)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign end_cl     = (limit_ff > CLUSTER_END) ? CLUSTER_END : limit_ff;
   assign cluster_ok = ({1'b0, cluster_ff} < CLUSTER_END);
   assign addr_ok    = ({1'b0, addr_ff} < TABLE_END);

   // row = addr / 3 from the registered product, lane = addr - 3 * row
   assign div_row   = prod_ff[fct_pkg::PROD_W-1:fct_pkg::DIV3_SHIFT];
   assign div_back  = AW'({div_row, 1'b0}) + AW'(div_row);
   assign lane_full = addr_ff - div_back;
   assign prod_in   = fct_pkg::PROD_W'(req_byte_address) * fct_pkg::PROD_W'(fct_pkg::DIV3_MUL);

   assign scan_done = (scan_ff >= end_cl);
   assign scan_odd  = scan_ff + LW'(1);
   assign even_hit  = row_stat.even_zero;
   assign odd_hit   = row_stat.odd_zero && (scan_odd < end_cl);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      row_in       = row_ff;
      push         = 1'b0;
      rsp_entry_in = '0;
      rsp_found_in = 1'b0;
      rsp_free_in  = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = row_ff;
      ram_wr_data  = row_merged;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[ROW_W:1];

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ROW_W'(1);
            if (clr_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               scan_in  = FIRST_FIND;
               state_in = (req_operation == fct_pkg::OP_FIND) ? S_FIND_RD : S_ISSUE;
            end
         end
         S_ISSUE: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = (op_ff == fct_pkg::OP_LOAD) ? div_row[ROW_W-1:0]
                                                      : cluster_ff[ROW_W:1];
            row_in      = ram_rd_addr;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == fct_pkg::OP_READ && cluster_ok) begin
               rsp_entry_in = row_entry;
            end
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
               if ((op_ff == fct_pkg::OP_FREE || op_ff == fct_pkg::OP_FULL) && cluster_ok) begin
                  ram_wr_en = 1'b1;
               end
               if (op_ff == fct_pkg::OP_LOAD && addr_ok) begin
                  ram_wr_en = 1'b1;
               end
            end
         end
         S_FIND_RD: begin
            if (scan_done) begin
               // limit reached: not found
               if (out_free) begin
                  push     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (even_hit || odd_hit) begin
               rsp_found_in = 1'b1;
               rsp_free_in  = even_hit ? scan_ff[CW-1:0] : scan_odd[CW-1:0];
               if (out_free) begin
                  push     = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               scan_in  = scan_ff + LW'(2);
               state_in = S_FIND_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         limit_ff     <= fct_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      row_ff  <= row_in;
      if (accept) begin
         op_ff      <= req_operation;
         cluster_ff <= req_cluster;
         addr_ff    <= req_byte_address;
         value_ff   <= req_byte_value;
         prod_ff    <= prod_in;
      end
      if (state_ff == S_ISSUE) begin
         lane_ff <= lane_full[1:0];
      end
      if (push) begin
         rsp_entry_ff <= rsp_entry_in;
         rsp_found_ff <= rsp_found_in;
         rsp_free_ff  <= rsp_free_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_value  = rsp_entry_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_free_cluster = rsp_free_ff;

   `FCT_ASSERT_IMPLY(a_no_accept_in_clear, state_ff == S_CLEAR, req_stall, "beat taken during clear")
   `FCT_ASSERT_IMPLY(a_wr_only_clear_exec, ram_wr_en, state_ff == S_CLEAR || state_ff == S_EXEC, "stray table write")
   `FCT_ASSERT_IMPLY(a_found_above_one, rsp_valid_ff && rsp_found_ff, rsp_free_ff >= CW'(2), "found cluster below 2")
   `FCT_ASSERT_IMPLY(a_miss_zero, rsp_valid_ff && !rsp_found_ff, rsp_free_ff == '0, "free cluster not zero on miss")
   `FCT_ASSERT_NEXT(a_accept_busy, accept, state_ff != S_IDLE, "idle after accept")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FAT12 cluster table engine. A queued driver
// feeds request beats and a monitor checks every response beat against a
// local copy of the packed table. Directed corner cases come first, then
// allocation-style random traffic over a series of search limit settings,
// with random request gaps and response stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CLUSTERS    = fct_pkg::CLUSTERS_DEFAULT;
   localparam int TABLE_BYTES = (CLUSTERS + 1) / 2 * 3;
   localparam int ITEM_TARGET = 650;
   localparam int PHASE_ITEMS = 65;
   localparam int ADDR_MAX    = (1 << fct_pkg::ADDR_W) - 1;
   localparam int LIMIT_MAX   = (1 << fct_pkg::LIMIT_W) - 1;

   // operation codes with no defined function
   localparam logic [fct_pkg::OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [fct_pkg::OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

   typedef struct packed {
      logic [fct_pkg::OP_W-1:0]      op;
      logic [fct_pkg::CLUSTER_W-1:0] cluster;
      logic [fct_pkg::ADDR_W-1:0]    addr;
      logic [fct_pkg::BYTE_W-1:0]    value;
   } fat_cmd_type;

   typedef struct packed {
      logic [fct_pkg::ENTRY_W-1:0]   entry;
      logic                          found;
      logic [fct_pkg::CLUSTER_W-1:0] free_cl;
   } fat_ans_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [fct_pkg::LIMIT_W-1:0]   csr_wr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [fct_pkg::OP_W-1:0]      req_operation = '0;
   logic [fct_pkg::CLUSTER_W-1:0] req_cluster = '0;
   logic [fct_pkg::ADDR_W-1:0]    req_byte_address = '0;
   logic [fct_pkg::BYTE_W-1:0]    req_byte_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [fct_pkg::ENTRY_W-1:0]   rsp_entry_value;
   logic                          rsp_found;
   logic [fct_pkg::CLUSTER_W-1:0] rsp_free_cluster;

   // shadow table and search bound
   logic [7:0]                  fat_bytes [TABLE_BYTES];
   logic [fct_pkg::LIMIT_W-1:0] find_limit;

   fat_cmd_type fat_cmds[$];
   fat_ans_type fat_answers[$];
   fat_cmd_type offer;

   int beats_in = 0;
   int beats_out = 0;
   int errors = 0;
   int n_hit = 0;
   int n_miss = 0;
   int n_cfg = 0;
   int real_items = 0;
   int phase_items = 0;
   int frontier = 2;

   logic [fct_pkg::LIMIT_W-1:0] limit_plan [10] = '{13'd4096, 13'd0, 13'd40, 13'd3, 13'd130,
                                                     13'd1, 13'd8191, 13'd2, 13'd700, 13'd4095};

   fat12_cluster_table_engine_core #(.CLUSTERS(CLUSTERS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_cluster      (req_cluster),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_found        (rsp_found),
      .rsp_free_cluster (rsp_free_cluster)
   );

   initial forever #2 clock = ~clock;

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [fct_pkg::ENTRY_W-1:0] fat_entry(input int c);
      int base;
      base = (c / 2) * 3;
      if (c >= CLUSTERS || base + 2 >= TABLE_BYTES) return '0;
      if (c % 2 == 0) return {fat_bytes[base+1][3:0], fat_bytes[base]};
      return {fat_bytes[base+2], fat_bytes[base+1][7:4]};
   endfunction

   // the shared middle byte keeps the neighbor's nibble
   function automatic void fat_set_entry(input int c, input logic [fct_pkg::ENTRY_W-1:0] v);
      int base;
      base = (c / 2) * 3;
      if (c >= CLUSTERS || base + 2 >= TABLE_BYTES) return;
      if (c % 2 == 0) begin
         fat_bytes[base]        = v[7:0];
         fat_bytes[base+1][3:0] = v[11:8];
      end else begin
         fat_bytes[base+2]      = v[11:4];
         fat_bytes[base+1][7:4] = v[3:0];
      end
   endfunction

   function automatic fat_ans_type fat_execute(input fat_cmd_type cmd);
      fat_ans_type ans;
      int stop;
      ans = '0;
      case (cmd.op)
         fct_pkg::OP_READ: ans.entry = fat_entry(int'(cmd.cluster));
         fct_pkg::OP_FREE: fat_set_entry(int'(cmd.cluster), fct_pkg::ENTRY_FREE);
         fct_pkg::OP_FULL: fat_set_entry(int'(cmd.cluster), fct_pkg::ENTRY_FULL);
         fct_pkg::OP_FIND: begin
            stop = (int'(find_limit) > CLUSTERS) ? CLUSTERS : int'(find_limit);
            for (int i = 2; i < stop && !ans.found; i++) begin
               if (fat_entry(i) == fct_pkg::ENTRY_FREE) begin
                  ans.found   = 1'b1;
                  ans.free_cl = fct_pkg::CLUSTER_W'(i);
               end
            end
            if (ans.found) n_hit++;
            else n_miss++;
         end
         fct_pkg::OP_LOAD: if (int'(cmd.addr) < TABLE_BYTES) fat_bytes[cmd.addr] = cmd.value;
         default: ;
      endcase
      return ans;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fat_answers.push_back(fat_execute(offer));
            beats_in++;
         end
         if (!req_valid || !req_stall) begin
            if (fat_cmds.size() != 0 &&
                ((beats_in >= 300 && beats_in < 420) || $urandom_range(99) >= 6)) begin
               offer = fat_cmds.pop_front();
               req_valid        <= 1'b1;
               req_operation    <= offer.op;
               req_cluster      <= offer.cluster;
               req_byte_address <= offer.addr;
               req_byte_value   <= offer.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fat_ans_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (fat_answers.size() == 0) begin
               $error("response beat with nothing outstanding");
               errors++;
            end else begin
               want = fat_answers.pop_front();
               if (rsp_entry_value !== want.entry) begin
                  $error("entry_value: expected %03h, got %03h", want.entry, rsp_entry_value);
                  errors++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  errors++;
               end
               if (rsp_free_cluster !== want.free_cl) begin
                  $error("free_cluster: expected %0d, got %0d", want.free_cl,
                         rsp_free_cluster);
                  errors++;
               end
            end
            beats_out++;
         end
         rsp_stall <= !(beats_out >= 300 && beats_out < 420) && $urandom_range(99) < 6;
      end
   end

   task automatic queue_op(input int op, input int cl, input int addr, input int val);
      fat_cmd_type c;
      c.op      = fct_pkg::OP_W'(op);
      c.cluster = fct_pkg::CLUSTER_W'(cl);
      c.addr    = fct_pkg::ADDR_W'(addr);
      c.value   = fct_pkg::BYTE_W'(val);
      fat_cmds.push_back(c);
      // undefined ops and loads past the table end are not counted
      if (c.op <= fct_pkg::OP_LOAD &&
          !(c.op == fct_pkg::OP_LOAD && int'(c.addr) >= TABLE_BYTES)) begin
         real_items++;
         phase_items++;
      end
   endtask

   task automatic drain();
      while (fat_cmds.size() != 0 || req_valid || fat_answers.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [fct_pkg::LIMIT_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      find_limit = v;
      n_cfg++;
   endtask

   task automatic random_burst();
      int kind;
      int c;
      int r;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2, 3: begin
            // grow the allocated prefix, then search past it
            repeat ($urandom_range(1, 12)) begin
               queue_op(fct_pkg::OP_FULL, frontier, $urandom, $urandom);
               if (frontier < CLUSTERS - 1) frontier++;
            end
            queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
         end
         4: queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
         5: begin
            repeat ($urandom_range(1, 4)) begin
               c = $urandom_range(1) ? $urandom_range(frontier + 4) : $urandom_range(CLUSTERS - 1);
               queue_op(fct_pkg::OP_READ, c, $urandom, $urandom);
            end
         end
         6: begin
            r = $urandom_range(1) ? $urandom_range(frontier / 2 + 2)
                                  : $urandom_range(TABLE_BYTES / 3 - 1);
            for (int b = 0; b < 3; b++)
               queue_op(fct_pkg::OP_LOAD, $urandom, 3 * r + b,
                        ($urandom_range(3) == 0) ? 0 : $urandom_range(255));
            queue_op(fct_pkg::OP_READ, 2 * r, $urandom, $urandom);
            queue_op(fct_pkg::OP_READ, 2 * r + 1, $urandom, $urandom);
         end
         7: begin
            c = $urandom_range(CLUSTERS - 1);
            queue_op($urandom_range(1) ? fct_pkg::OP_FULL : fct_pkg::OP_FREE, c, $urandom,
                     $urandom);
            queue_op(fct_pkg::OP_READ, c, $urandom, $urandom);
            queue_op(fct_pkg::OP_READ, c ^ 1, $urandom, $urandom);
         end
         8: begin
            if ($urandom_range(1))
               queue_op($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST), $urandom, $urandom,
                        $urandom);
            else
               queue_op(fct_pkg::OP_LOAD, $urandom, $urandom_range(TABLE_BYTES, ADDR_MAX),
                        $urandom);
         end
         default: begin
            // punch a hole in the prefix, find it, refill it
            c = $urandom_range(2, (frontier > 2) ? frontier - 1 : 2);
            queue_op(fct_pkg::OP_FREE, c, $urandom, $urandom);
            queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
            queue_op(fct_pkg::OP_FULL, c, $urandom, $urandom);
         end
      endcase
   endtask

   initial begin
      logic [fct_pkg::LIMIT_W-1:0] lim;
      int p;
      for (int i = 0; i < TABLE_BYTES; i++) fat_bytes[i] = '0;
      find_limit = fct_pkg::LIMIT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset limit
      queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 0, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, CLUSTERS - 1, $urandom, $urandom);
      queue_op(fct_pkg::OP_FULL, 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_FULL, 3, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 3, $urandom, $urandom);
      queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
      queue_op(fct_pkg::OP_FREE, 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 3, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_LOAD, $urandom, 0, 8'hAB);
      queue_op(fct_pkg::OP_LOAD, $urandom, 1, 8'hCD);
      queue_op(fct_pkg::OP_LOAD, $urandom, 2, 8'hEF);
      queue_op(fct_pkg::OP_READ, 0, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, 1, $urandom, $urandom);
      queue_op(fct_pkg::OP_LOAD, $urandom, TABLE_BYTES - 1, 8'hFF);
      queue_op(fct_pkg::OP_LOAD, $urandom, TABLE_BYTES, 8'h55);
      queue_op(fct_pkg::OP_LOAD, $urandom, ADDR_MAX, 8'hAA);
      queue_op(fct_pkg::OP_READ, CLUSTERS - 1, $urandom, $urandom);
      queue_op(fct_pkg::OP_FULL, CLUSTERS - 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, CLUSTERS - 2, $urandom, $urandom);
      queue_op(fct_pkg::OP_FREE, CLUSTERS - 1, $urandom, $urandom);
      queue_op(fct_pkg::OP_READ, CLUSTERS - 2, $urandom, $urandom);
      for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++)
         queue_op(op, $urandom, $urandom, $urandom);

      // random phases, one search limit each
      for (p = 0; real_items < ITEM_TARGET; p++) begin
         drain();
         if (p < 10) lim = limit_plan[p];
         else if ($urandom_range(1)) lim = fct_pkg::LIMIT_W'($urandom_range(300));
         else lim = fct_pkg::LIMIT_W'($urandom_range(CLUSTERS, LIMIT_MAX));
         write_limit(lim);
         phase_items = 0;
         queue_op(fct_pkg::OP_FIND, $urandom, $urandom, $urandom);
         while (phase_items < PHASE_ITEMS) random_burst();
      end

      drain();
      repeat (16) @(posedge clock);
      $display("run covered %0d request beats, %0d response beats, %0d limit settings",
               beats_in, beats_out, n_cfg);
      $display("searches: %0d hits, %0d misses", n_hit, n_miss);
      if (errors == 0 && fat_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
